@@ hdl/spn_pkg.sv @@
// spn_pkg: shared constants, beat type and round functions for the 16-bit SPN cipher.
// Used by spn_cell, spn_block_cipher_16bit, spn_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spn_pkg;

    localparam int unsigned BLOCK_W   = 16;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned NUM_CELLS = 4;
    localparam logic [KEY_W-1:0] KEY_RESET = 32'h3A94_D63F;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;

    typedef struct packed {
        logic   valid;
        logic   cmd;
        block_t data;
    } beat_t;

    localparam logic [3:0] FWD_SBOX [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };

    localparam logic [3:0] INV_SBOX [16] = '{
        4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
        4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
    };

    function automatic block_t subst(input block_t x, input logic inv);
        block_t y;
        y = '0;
        for (int n = 0; n < 4; n++)
        begin
            if (inv)
                y[4*n +: 4] = INV_SBOX[x[4*n +: 4]];
            else
                y[4*n +: 4] = FWD_SBOX[x[4*n +: 4]];
        end
        return y;
    endfunction

    // bit at MSB-position 4j+t moves to MSB-position 4t+j
    function automatic block_t transpose(input block_t x);
        block_t y;
        y = '0;
        for (int t = 0; t < 4; t++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                y[15 - (4*t + j)] = x[15 - (4*j + t)];
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

@@ hdl/spn_cell.sv @@
// spn_cell: one round of the cipher pipeline (key XOR, S-box layer, optional transpose).
// Depends on spn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spn_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            perm_en,
    input  wire spn_pkg::block_t enc_key,
    input  wire spn_pkg::block_t dec_key,
    input  wire spn_pkg::beat_t  beat_in,
    output spn_pkg::beat_t       beat_out
);
    import spn_pkg::*;

    logic   valid_reg;
    logic   cmd_reg;
    block_t data_reg;
    block_t data_next;
    block_t mixed;
    block_t subbed;

    always_comb
    begin
        mixed     = beat_in.data ^ ((beat_in.cmd == CMD_DECRYPT) ? dec_key : enc_key);
        subbed    = subst(mixed, beat_in.cmd == CMD_DECRYPT);
        data_next = perm_en ? transpose(subbed) : subbed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= beat_in.valid;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= beat_in.cmd;
        data_reg <= data_next;
    end

    assign beat_out.valid = valid_reg;
    assign beat_out.cmd   = cmd_reg;
    assign beat_out.data  = data_reg;

endmodule

`default_nettype wire

@@ hdl/spn_block_cipher_16bit.sv @@
// spn_block_cipher_16bit: top level of the 16-bit SPN block cipher, a row of round cells.
// Depends on spn_pkg and spn_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Command channel: drive command (0 encrypt, 1 decrypt) and block_in with start
//   high; a beat is taken at every edge where start is high and busy is low.
//   busy never rises, so a new block can enter in every cycle.
//   Result channel: done rises with block_out once a beat has passed the four round
//   cells and the output register; the receiver takes the beat while done is high.
//   Throughput is one block per cycle; up to five blocks are in flight.
//   The receiver cannot stall; results come out in order regardless.
//   Key register: APB write where paddr[2] is low (pready always high); reads there return it.
//   Change the key only while no block is in flight, since the round keys are
//   taken live from it by every cell.
//   Reset clears all valid flags and loads the default key 0x3A94D63F.
module spn_block_cipher_16bit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic            command,
    input  wire spn_pkg::block_t block_in,
    output logic                 done,
    output spn_pkg::block_t      block_out,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [2:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import spn_pkg::*;

    localparam int unsigned CELLS = NUM_CELLS;

    logic [KEY_W-1:0] key_reg;
    logic             done_reg;
    block_t           block_out_reg;
    block_t           round_key [CELLS+1];
    block_t           final_key;
    beat_t            chain [CELLS+1];
    logic             key_wr;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign key_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? '0 : key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= KEY_RESET;
        else if (key_wr)
            key_reg <= pwdata;
    end

    for (genvar r = 0; r <= CELLS; r++)
    begin : g_rk
        assign round_key[r] = key_reg[KEY_W-1-4*r -: BLOCK_W];
    end

    assign chain[0].valid = start && !busy;
    assign chain[0].cmd   = command;
    assign chain[0].data  = block_in;

    for (genvar r = 0; r < CELLS; r++)
    begin : g_cell
        block_t dec_key;
        if (r == 0)
        begin : g_first
            assign dec_key = round_key[CELLS];
        end
        else
        begin : g_rest
            assign dec_key = transpose(round_key[CELLS-r]);
        end

        spn_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .perm_en  (r < CELLS-1),
            .enc_key  (round_key[r]),
            .dec_key  (dec_key),
            .beat_in  (chain[r]),
            .beat_out (chain[r+1])
        );
    end

    assign final_key = (chain[CELLS].cmd == CMD_DECRYPT) ? round_key[0] : round_key[CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain[CELLS].valid;
    end

    always_ff @(posedge clk)
    begin
        block_out_reg <= chain[CELLS].data ^ final_key;
    end

    assign done      = done_reg;
    assign block_out = block_out_reg;

endmodule

`default_nettype wire

@@ hdl/spn_checker.sv @@
// spn_checker: port-level assertions for spn_block_cipher_16bit, bound to the top level.
// Depends on spn_pkg and spn_block_cipher_16bit.
`timescale 1ns / 1ps
`default_nettype none

module spn_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic pready
);
    import spn_pkg::*;

    localparam int unsigned LAT = NUM_CELLS + 1;

    a_beat_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted beat produced no result");

    a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without matching accepted beat");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind spn_block_cipher_16bit spn_checker u_spn_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);

`default_nettype wire

@@ tb/spn_block_cipher_16bit_tb.sv @@
// spn_block_cipher_16bit_tb: self-checking testbench for the 16-bit SPN block cipher.
// Drives the command and APB ports, and predicts every block_out beat in a scoreboard class.
// Depends on spn_pkg and spn_block_cipher_16bit.
`timescale 1ns / 1ps

module spn_block_cipher_16bit_tb;

    import spn_pkg::*;

    localparam int          LATENCY     = 5;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          PHASE_ITEMS = 250;
    localparam int          NUM_PHASES  = 7;
    localparam logic [2:0]  KEY_ADDR    = 3'd0;
    localparam logic [2:0]  UNUSED_ADDR = 3'd4;

    localparam bit [3:0] SBOX_ENC [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };
    localparam bit [3:0] SBOX_DEC [16] = '{
        4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
        4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
    };

    class cipher_scoreboard;
        bit [31:0] key;
        bit [15:0] expected_blocks [$];
        int        errors;

        function new();
            key    = KEY_RESET;
            errors = 0;
        endfunction

        function bit [15:0] round_key(int r);
            bit [31:0] shifted;
            shifted = key >> (16 - 4 * r);
            return shifted[15:0];
        endfunction

        function bit [15:0] sub_nibbles(bit [15:0] x, bit inv);
            bit [15:0] y;
            for (int n = 0; n < 4; n++)
            begin
                y[4*n +: 4] = inv ? SBOX_DEC[x[4*n +: 4]] : SBOX_ENC[x[4*n +: 4]];
            end
            return y;
        endfunction

        // 4x4 bit matrix transpose, self-inverse
        function bit [15:0] transpose_bits(bit [15:0] x);
            bit [15:0] y;
            for (int a = 0; a < 4; a++)
            begin
                for (int b = 0; b < 4; b++)
                begin
                    y[4*a + b] = x[4*b + a];
                end
            end
            return y;
        endfunction

        function bit [15:0] spn_cipher(bit cmd, bit [15:0] blk);
            bit [15:0] x;
            x = blk;
            if (cmd == CMD_ENCRYPT)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    x = transpose_bits(sub_nibbles(x ^ round_key(r), 1'b0));
                end
                x = sub_nibbles(x ^ round_key(3), 1'b0) ^ round_key(4);
            end
            else
            begin
                x = sub_nibbles(x ^ round_key(4), 1'b1) ^ round_key(3);
                for (int r = 3; r > 0; r--)
                begin
                    x = sub_nibbles(transpose_bits(x), 1'b1) ^ round_key(r - 1);
                end
            end
            return x;
        endfunction

        function void report_mismatch(string what, bit [31:0] expected, bit [31:0] actual);
            errors++;
            if (errors <= 10)
            begin
                $display("mismatch %0s: expected %h, actual %h at %0t",
                         what, expected, actual, $realtime);
            end
        endfunction

        function void note_block(bit cmd, bit [15:0] blk);
            expected_blocks.push_back(spn_cipher(cmd, blk));
        endfunction

        function void check_block(bit [15:0] actual);
            bit [15:0] expected;
            if (expected_blocks.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected block_out beat %h at %0t", actual, $realtime);
                end
            end
            else
            begin
                expected = expected_blocks.pop_front();
                if (expected !== actual)
                begin
                    report_mismatch("block_out", {16'h0, expected}, {16'h0, actual});
                end
            end
        endfunction

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        command;
    block_t      block_in;
    logic        done;
    block_t      block_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cipher_scoreboard sb;
    int               cycles;

    spn_block_cipher_16bit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .block_in  (block_in),
        .done      (done),
        .block_out (block_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done && sb != null)
        begin
            sb.check_block(block_out);
        end
    end

    task automatic send_block(input bit cmd, input bit [15:0] blk);
        @(negedge clk);
        start    <= 1'b1;
        command  <= cmd;
        block_in <= blk;
        do @(posedge clk); while (busy);
        sb.note_block(cmd, blk);
    endtask

    // start low, with junk on the payload, for an idle gap whose length is set by n
    task automatic idle_sender(input int n);
        @(negedge clk);
        start    <= 1'b0;
        command  <= 1'($urandom_range(0, 1));
        block_in <= 16'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == KEY_ADDR)
        begin
            sb.key = data;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check_key();
        logic [31:0] value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= KEY_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
        if (value !== sb.key)
        begin
            sb.report_mismatch("cipher_key readback", sb.key, value);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_block();
        bit        cmd;
        bit [15:0] blk;
        int        sel;
        sel = $urandom_range(0, 7);
        cmd = 1'($urandom_range(0, 1));
        blk = 16'($urandom);
        if (sel == 0)
        begin
            blk = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        else if (sel <= 3)
        begin
            // feed the inverse direction a block produced by the other one
            blk = sb.spn_cipher(~cmd, 16'($urandom));
        end
        send_block(cmd, blk);
    endtask

    task automatic run_phase(input int n);
        int count;
        int burst;
        count = 0;
        while (count < n)
        begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
            for (int i = 0; i < burst && count < n; i++)
            begin
                send_random_block();
                count++;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                drain_results();
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                idle_sender($urandom_range(1, 8));
            end
        end
    endtask

    initial
    begin
        bit [15:0] directed [6];
        bit [31:0] phase_key;
        bit [15:0] pt;

        directed = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA, 16'h5555};
        sb       = new();
        cycles   = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        command  = 1'b0;
        block_in = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        apb_check_key();
        for (int c = 0; c < 2; c++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                send_block(c[0], directed[i]);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            pt = 16'($urandom);
            send_block(CMD_ENCRYPT, pt);
            send_block(CMD_DECRYPT, sb.spn_cipher(CMD_ENCRYPT, pt));
        end
        drain_results();

        // write to an unmapped register must leave the key alone
        apb_write(UNUSED_ADDR, $urandom);
        apb_check_key();
        send_block(CMD_ENCRYPT, 16'h1234);
        send_block(CMD_DECRYPT, 16'h1234);
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                case (p)
                    1:       phase_key = 32'h0000_0000;
                    2:       phase_key = 32'hFFFF_FFFF;
                    3:       phase_key = 32'hFFFF_0000;
                    default: phase_key = $urandom;
                endcase
                apb_write(KEY_ADDR, phase_key);
                apb_check_key();
            end
            run_phase(PHASE_ITEMS);
            drain_results();
        end

        repeat (LATENCY * 2) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
